/* rtl/rc_pulse_width_decoder_top_defines.svh */
// ----------------------------------------------------------------------------
// RC pulse width decoder assertion macros
// Shared property forms for the decoder's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef RC_PULSE_WIDTH_DECODER_TOP_DEFINES_SVH
`define RC_PULSE_WIDTH_DECODER_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define RPWD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define RPWD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/rcpwd_pkg.sv */
// ----------------------------------------------------------------------------
// rcpwd_pkg
// Types and fixed constants of the RC pulse width decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package rcpwd_pkg;

    localparam int PIN_W      = 4;
    localparam int STAMP_W    = 32;
    localparam int TICK_W     = 16;
    localparam int DUTY_W     = 13;
    localparam int MASK_W     = 4;
    localparam int ROLE_COUNT = 4;
    localparam int CFG_IDX_W  = 2;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_MIN_TICKS = 2'd0;
    localparam t_cfg_idx CFG_MAX_TICKS = 2'd1;
    localparam t_cfg_idx CFG_ROLE_MODE = 2'd2;

    localparam logic [TICK_W-1:0] MIN_TICKS_RST = 16'd1000;
    localparam logic [TICK_W-1:0] MAX_TICKS_RST = 16'd2000;

    typedef logic [1:0] t_role_ch;

    // role order: throttle, roll, pitch, yaw
    localparam t_role_ch ROLE_MAP_ONE [ROLE_COUNT] = '{2'd0, 2'd3, 2'd2, 2'd1};
    localparam t_role_ch ROLE_MAP_TWO [ROLE_COUNT] = '{2'd2, 2'd1, 2'd0, 2'd3};

    localparam int ROLE_THROTTLE = 0;
    localparam int ROLE_ROLL     = 1;
    localparam int ROLE_PITCH    = 2;
    localparam int ROLE_YAW      = 3;

    typedef struct packed {
        logic load;
        logic scan;
        logic adv;
        logic eval;
        logic div_step;
        logic store;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic fall;
        logic last_ch;
        logic need_div;
        logic div_last;
        logic out_free;
    } t_dp_status;

endpackage

`default_nettype wire

/* rtl/rcpwd_ctrl.sv */
// ----------------------------------------------------------------------------
// rcpwd_ctrl
// Sequencer: walks the channels of one beat, runs the shared divider on
// falling edges whose width lies between the limits and hands the result to
// the output register.
`default_nettype none

module rcpwd_ctrl (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_stall,
    input  rcpwd_pkg::t_dp_status i_status,
    output rcpwd_pkg::t_dp_cmd   o_cmd
);
    import rcpwd_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;
    localparam logic [2:0] ST_EVAL  = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_STORE = 3'd4;
    localparam logic [2:0] ST_EMIT  = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_status.fall) begin
                    n_state = ST_EVAL;
                end else if (i_status.last_ch) begin
                    n_state = ST_EMIT;
                end else begin
                    o_cmd.adv = 1'b1;
                end
            end
            ST_EVAL: begin
                o_cmd.eval = 1'b1;
                if (i_status.need_div) begin
                    n_state = ST_DIV;
                end else if (i_status.last_ch) begin
                    n_state = ST_EMIT;
                end else begin
                    o_cmd.adv = 1'b1;
                    n_state   = ST_SCAN;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = ST_STORE;
                end
            end
            ST_STORE: begin
                o_cmd.store = 1'b1;
                if (i_status.last_ch) begin
                    n_state = ST_EMIT;
                end else begin
                    o_cmd.adv = 1'b1;
                    n_state   = ST_SCAN;
                end
            end
            ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != ST_IDLE);

endmodule

`default_nettype wire

/* rtl/rcpwd_datapath.sv */
// ----------------------------------------------------------------------------
// rcpwd_datapath
// Channel state, width capture, duty mapping with a radix-2 restoring
// divider, role selection and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rcpwd_datapath #(
    parameter int CHANNEL_COUNT  = 4,
    parameter int TIME_BITS      = 32,
    parameter int DUTY_FRAC_BITS = 12
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_cfg_wr_en,
    input  wire  [rcpwd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire  [rcpwd_pkg::TICK_W-1:0]    i_cfg_wdata,
    input  wire  [rcpwd_pkg::PIN_W-1:0]     i_pin_levels,
    input  wire  [rcpwd_pkg::STAMP_W-1:0]   i_timestamp,
    input  wire                             i_out_stall,
    input  rcpwd_pkg::t_dp_cmd              i_cmd,
    output rcpwd_pkg::t_dp_status           o_status,
    output logic                            o_out_valid,
    output logic [rcpwd_pkg::DUTY_W-1:0]    o_throttle_duty,
    output logic [rcpwd_pkg::DUTY_W-1:0]    o_roll_duty,
    output logic [rcpwd_pkg::DUTY_W-1:0]    o_pitch_duty,
    output logic [rcpwd_pkg::DUTY_W-1:0]    o_yaw_duty,
    output logic [rcpwd_pkg::MASK_W-1:0]    o_completed_mask
);
    import rcpwd_pkg::*;

    localparam int CH_W   = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
    localparam int STEP_W = $clog2(DUTY_FRAC_BITS + 1);
    localparam logic [DUTY_W-1:0] DUTY_FULL = DUTY_W'(64'd1 << DUTY_FRAC_BITS);

    logic [TICK_W-1:0]          r_min;
    logic [TICK_W-1:0]          r_max;
    logic                       r_mode;

    logic [TIME_BITS-1:0]       r_now;
    logic [CHANNEL_COUNT-1:0]   r_pins;
    logic [CHANNEL_COUNT-1:0]   r_flags;
    logic [CHANNEL_COUNT-1:0]   r_done;
    logic [TIME_BITS-1:0]       r_start [CHANNEL_COUNT];
    logic [DUTY_W-1:0]          r_duty  [CHANNEL_COUNT];
    logic [CH_W-1:0]            r_ch;
    logic [TIME_BITS-1:0]       r_width;

    logic [TICK_W-1:0]          r_rem;
    logic [TICK_W-1:0]          r_dvs;
    logic [DUTY_FRAC_BITS-1:0]  r_quot;
    logic [STEP_W-1:0]          r_step;

    logic [DUTY_W-1:0]          r_out_duty [ROLE_COUNT];
    logic [MASK_W-1:0]          r_out_mask;
    logic                       r_out_valid;

    logic [CHANNEL_COUNT-1:0]   w_pins_ext;
    logic [MASK_W-1:0]          w_done_mask;
    logic [DUTY_W-1:0]          w_duty_pad [ROLE_COUNT];
    logic [DUTY_W-1:0]          w_role_duty [ROLE_COUNT];

    logic                       w_level;
    logic                       w_was_high;
    logic                       w_ge_max;
    logic                       w_le_min;
    logic [TICK_W:0]            w_trial;
    logic                       w_fits;
    logic [TICK_W-1:0]          n_rem;

    genvar g;

    generate
        for (g = 0; g < CHANNEL_COUNT; g++) begin : g_pins
            if (g < PIN_W) begin : g_real
                assign w_pins_ext[g] = i_pin_levels[g];
            end else begin : g_none
                assign w_pins_ext[g] = 1'b0;
            end
        end
        for (g = 0; g < MASK_W; g++) begin : g_mask
            if (g < CHANNEL_COUNT) begin : g_real
                assign w_done_mask[g] = r_done[g];
            end else begin : g_none
                assign w_done_mask[g] = 1'b0;
            end
        end
        for (g = 0; g < ROLE_COUNT; g++) begin : g_pad
            if (g < CHANNEL_COUNT) begin : g_real
                assign w_duty_pad[g] = r_duty[g];
            end else begin : g_none
                assign w_duty_pad[g] = '0;
            end
        end
        for (g = 0; g < ROLE_COUNT; g++) begin : g_role
            assign w_role_duty[g] = r_mode ? w_duty_pad[ROLE_MAP_TWO[g]]
                                           : w_duty_pad[ROLE_MAP_ONE[g]];
        end
    endgenerate

    assign w_level    = r_pins[r_ch];
    assign w_was_high = r_flags[r_ch];
    assign w_ge_max   = (r_width >= TIME_BITS'(r_max));
    assign w_le_min   = (r_width <= TIME_BITS'(r_min));

    assign w_trial = {r_rem, 1'b0};
    assign w_fits  = (w_trial >= {1'b0, r_dvs});

    always_comb begin
        if (w_fits) begin
            n_rem = TICK_W'(w_trial - {1'b0, r_dvs});
        end else begin
            n_rem = TICK_W'(w_trial);
        end
    end

    assign o_status.fall     = w_was_high && !w_level;
    assign o_status.last_ch  = (r_ch == CH_W'(CHANNEL_COUNT - 1));
    assign o_status.need_div = !w_ge_max && !w_le_min;
    assign o_status.div_last = (r_step == STEP_W'(DUTY_FRAC_BITS - 1));
    assign o_status.out_free = !r_out_valid || !i_out_stall;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min  <= MIN_TICKS_RST;
            r_max  <= MAX_TICKS_RST;
            r_mode <= 1'b0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_MIN_TICKS: r_min  <= i_cfg_wdata;
                CFG_MAX_TICKS: r_max  <= i_cfg_wdata;
                CFG_ROLE_MODE: r_mode <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // channel state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
            r_done  <= '0;
            r_ch    <= '0;
            for (int k = 0; k < CHANNEL_COUNT; k++) begin
                r_start[k] <= '0;
                r_duty[k]  <= '0;
            end
        end else begin
            if (i_cmd.load) begin
                r_done <= '0;
                r_ch   <= '0;
            end
            if (i_cmd.adv) begin
                r_ch <= r_ch + CH_W'(1);
            end
            if (i_cmd.scan) begin
                if (!w_was_high && w_level) begin
                    r_start[r_ch] <= r_now;
                    r_flags[r_ch] <= 1'b1;
                end else if (w_was_high && !w_level) begin
                    r_flags[r_ch] <= 1'b0;
                    r_done[r_ch]  <= 1'b1;
                end
            end
            if (i_cmd.eval) begin
                if (w_ge_max) begin
                    r_duty[r_ch] <= DUTY_FULL;
                end else if (w_le_min) begin
                    r_duty[r_ch] <= '0;
                end
            end
            if (i_cmd.store) begin
                r_duty[r_ch] <= DUTY_W'(r_quot);
            end
        end
    end

    // beat capture, width and divider
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_now  <= TIME_BITS'(i_timestamp);
            r_pins <= w_pins_ext;
        end
        if (i_cmd.scan) begin
            r_width <= r_now - r_start[r_ch];
        end
        if (i_cmd.eval) begin
            r_rem  <= TICK_W'(r_width) - r_min;
            r_dvs  <= r_max - r_min;
            r_quot <= '0;
            r_step <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem  <= n_rem;
            r_quot <= {r_quot[DUTY_FRAC_BITS-2:0], w_fits};
            r_step <= r_step + STEP_W'(1);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            for (int k = 0; k < ROLE_COUNT; k++) begin
                r_out_duty[k] <= w_role_duty[k];
            end
            r_out_mask <= w_done_mask;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_throttle_duty  = r_out_duty[ROLE_THROTTLE];
    assign o_roll_duty      = r_out_duty[ROLE_ROLL];
    assign o_pitch_duty     = r_out_duty[ROLE_PITCH];
    assign o_yaw_duty       = r_out_duty[ROLE_YAW];
    assign o_completed_mask = r_out_mask;

endmodule

`default_nettype wire

/* rtl/rc_pulse_width_decoder_top.sv */
// ----------------------------------------------------------------------------
// rc_pulse_width_decoder_top
// Four-channel RC pulse width decoder: captures pulse widths from sampled
// pin levels and maps them to throttle, roll, pitch and yaw duties.
//
//   channel   direction  handshake                    payload
//   input     in         i_in_valid / o_in_stall      pin_levels, timestamp
//   output    out        o_out_valid / i_out_stall    four duties, completed_mask
//   config    in         i_cfg_wr_en                  i_cfg_index, i_cfg_wdata
//
// A beat is captured, then each channel is scanned in turn; a channel with a
// falling edge is checked against the limits and, when its width lies between
// them, goes through the shared one-bit-per-cycle divider before its duty is
// stored. Last the output register is loaded. The load waits while a stalled
// result holds the output register; a new beat is taken once it is loaded.
// Synchronous active-low reset clears all channel state and loads the
// register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rc_pulse_width_decoder_top_defines.svh"

module rc_pulse_width_decoder_top #(
    parameter int CHANNEL_COUNT  = 4,
    parameter int TIME_BITS      = 32,
    parameter int DUTY_FRAC_BITS = 12
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_cfg_wr_en,
    input  wire  [rcpwd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire  [rcpwd_pkg::TICK_W-1:0]    i_cfg_wdata,
    input  wire                             i_in_valid,
    output logic                            o_in_stall,
    input  wire  [rcpwd_pkg::PIN_W-1:0]     i_pin_levels,
    input  wire  [rcpwd_pkg::STAMP_W-1:0]   i_timestamp,
    output logic                            o_out_valid,
    input  wire                             i_out_stall,
    output logic [rcpwd_pkg::DUTY_W-1:0]    o_throttle_duty,
    output logic [rcpwd_pkg::DUTY_W-1:0]    o_roll_duty,
    output logic [rcpwd_pkg::DUTY_W-1:0]    o_pitch_duty,
    output logic [rcpwd_pkg::DUTY_W-1:0]    o_yaw_duty,
    output logic [rcpwd_pkg::MASK_W-1:0]    o_completed_mask
);
    import rcpwd_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    rcpwd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    rcpwd_datapath #(
        .CHANNEL_COUNT  (CHANNEL_COUNT),
        .TIME_BITS      (TIME_BITS),
        .DUTY_FRAC_BITS (DUTY_FRAC_BITS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_pin_levels     (i_pin_levels),
        .i_timestamp      (i_timestamp),
        .i_out_stall      (i_out_stall),
        .i_cmd            (w_cmd),
        .o_status         (w_status),
        .o_out_valid      (o_out_valid),
        .o_throttle_duty  (o_throttle_duty),
        .o_roll_duty      (o_roll_duty),
        .o_pitch_duty     (o_pitch_duty),
        .o_yaw_duty       (o_yaw_duty),
        .o_completed_mask (o_completed_mask)
    );

    `RPWD_ASSERT_NEXT(a_busy_after_accept, i_in_valid && !o_in_stall, o_in_stall, "beat accepted but input not stalled")
    `RPWD_ASSERT_NOW(a_emit_when_free, w_cmd.emit, !o_out_valid || !i_out_stall, "result overwrites a waiting beat")
    `RPWD_ASSERT_NOW(a_one_command, 1'b1, $onehot0({w_cmd.load, w_cmd.scan, w_cmd.eval, w_cmd.div_step, w_cmd.store, w_cmd.emit}), "more than one datapath command")

endmodule

`default_nettype wire
